// ===== rtl/iqfd_pkg.sv =====
// ----------------------------------------------------------------------------
// iqfd_pkg
// Shared types, codes and constants of the IQ frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package iqfd_pkg;

  localparam int unsigned MAX_SAMPLES  = 65536;
  localparam int unsigned HEADER_BYTES = 20;
  localparam int unsigned SAMPLE_BYTES = 8;

  localparam logic [31:0] RATE_DEFAULT = 32'd48000;
  localparam logic [31:0] MAX_COUNT    = 32'(MAX_SAMPLES);
  localparam logic [4:0]  HDR_LAST_POS = 5'(HEADER_BYTES - 1);
  localparam logic [4:0]  HDR_SEQ_POS  = 5'd8;
  localparam logic [4:0]  HDR_RATE_POS = 5'd12;
  localparam logic [4:0]  HDR_CNT_POS  = 5'd16;
  localparam logic [2:0]  SMP_Q_POS    = 3'(SAMPLE_BYTES / 2);
  localparam logic [2:0]  SMP_LAST_POS = 3'(SAMPLE_BYTES - 1);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_SAMPLES = 2'd1,
    PH_HALTED  = 2'd2
  } phase_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_ERROR  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ERR_BAD_HEADER = 2'd0,
    ERR_OVERSIZED  = 2'd1,
    ERR_LOST_FRAME = 2'd2
  } err_t;

  // Error code field of a sample result.
  localparam logic [1:0] ERR_NONE = 2'd0;

  typedef struct packed {
    logic        kind;
    logic [1:0]  error_code;
    logic [31:0] i_bits;
    logic [31:0] q_bits;
    logic [31:0] frame_sequence;
    logic        last_in_frame;
  } result_t;

  // Fixed part of the header: magic, version, type, header length.
  function automatic logic [7:0] fixed_head_byte(input logic [2:0] idx);
    logic [7:0] val;
    unique case (idx)
      3'd0:    val = 8'h46;
      3'd1:    val = 8'h31;
      3'd2:    val = 8'h35;
      3'd3:    val = 8'h49;
      3'd4:    val = 8'h01;
      3'd5:    val = 8'h01;
      3'd6:    val = 8'h00;
      default: val = 8'h14;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/iq_frame_deframer.sv =====
// An accepted word waits in the input register, is decoded by the core
//   combinationally and has its result loaded into the output register.
// Throughput: one word per cycle; the input register and the output register
//   move together whenever the output register is empty or being taken.
// Reset: synchronous active-low rst_n clears the valid flags of both registers
//   and the frame state, and sets expected_rate to 48000.
// ----------------------------------------------------------------------------
// iq_frame_deframer
// Byte-stream IQ frame deframer: header check, sequence check, sample words.
// ----------------------------------------------------------------------------
`default_nettype none

module iq_frame_deframer
  import iqfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [7:0]  in_data_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_kind,
  output logic [1:0]       out_error_code,
  output logic [31:0]      out_i_bits,
  output logic [31:0]      out_q_bits,
  output logic [31:0]      out_frame_sequence,
  output logic             out_last_in_frame
);

  // Input register: holds the word waiting to be decoded.
  logic       in_valid_r;
  logic       in_cmd_r;
  logic [7:0] in_byte_r;

  // Output register: holds the finished result until taken.
  logic       out_valid_r;
  result_t    out_res_r;

  logic       advance;
  logic       step;
  logic       res_valid;
  result_t    res;

  // Advance the pipe when the output register is free or drains this cycle.
  assign advance  = !out_valid_r || !out_stall;
  assign step     = in_valid_r && advance;
  // Stall the input only while a held word cannot move on.
  assign in_stall = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_cmd_r  <= in_command;
      in_byte_r <= in_data_byte;
    end
  end

  iqfd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .step      (step),
    .command   (in_cmd_r),
    .data_byte (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Load a result when the pipe advances; drop the valid flag when taken
  // and nothing new arrives.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_res_r.kind;
  assign out_error_code     = out_res_r.error_code;
  assign out_i_bits         = out_res_r.i_bits;
  assign out_q_bits         = out_res_r.q_bits;
  assign out_frame_sequence = out_res_r.frame_sequence;
  assign out_last_in_frame  = out_res_r.last_in_frame;

endmodule

`default_nettype wire

// ===== rtl/iqfd_core.sv =====
// ----------------------------------------------------------------------------
// iqfd_core
// Frame state and per-word decode: header check, sample assembly, errors.
// ----------------------------------------------------------------------------
`default_nettype none

module iqfd_core
  import iqfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data,
  input  wire logic        step,
  input  wire logic        command,
  input  wire logic [7:0]  data_byte,
  output logic             res_valid,
  output result_t          res
);

  logic [31:0] exp_rate_r;
  phase_t      phase_r,     phase_nxt;
  logic [4:0]  hpos_r,      hpos_nxt;
  logic        hok_r,       hok_nxt;
  logic [31:0] seq_r,       seq_nxt;
  logic [31:0] rate_r,      rate_nxt;
  logic [31:0] count_r,     count_nxt;
  logic [16:0] left_r,      left_nxt;
  logic [2:0]  sbp_r,       sbp_nxt;
  logic [31:0] i_asm_r,     i_asm_nxt;
  logic [23:0] q_asm_r,     q_asm_nxt;
  logic        have_prev_r, have_prev_nxt;
  logic [31:0] next_seq_r,  next_seq_nxt;

  logic [31:0] count_fin;
  logic [16:0] left_dec;
  logic [1:0]  q_lane;

  assign count_fin = {count_r[23:0], data_byte};
  assign left_dec  = left_r - 17'd1;
  assign q_lane    = 2'(sbp_r - SMP_Q_POS);

  always_comb begin
    phase_nxt     = phase_r;
    hpos_nxt      = hpos_r;
    hok_nxt       = hok_r;
    seq_nxt       = seq_r;
    rate_nxt      = rate_r;
    count_nxt     = count_r;
    left_nxt      = left_r;
    sbp_nxt       = sbp_r;
    i_asm_nxt     = i_asm_r;
    q_asm_nxt     = q_asm_r;
    have_prev_nxt = have_prev_r;
    next_seq_nxt  = next_seq_r;
    res_valid     = 1'b0;
    res           = '0;

    if (step) begin
      if (command) begin
        have_prev_nxt = 1'b0;
        phase_nxt     = PH_HEADER;
        hpos_nxt      = '0;
        hok_nxt       = 1'b1;
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            if (hpos_r < HDR_SEQ_POS) begin
              if (data_byte != fixed_head_byte(hpos_r[2:0])) begin
                hok_nxt = 1'b0;
              end
            end else if (hpos_r < HDR_RATE_POS) begin
              seq_nxt = {seq_r[23:0], data_byte};
            end else if (hpos_r < HDR_CNT_POS) begin
              rate_nxt = {rate_r[23:0], data_byte};
            end else begin
              count_nxt = count_fin;
            end

            if (hpos_r != HDR_LAST_POS) begin
              hpos_nxt = hpos_r + 5'd1;
            end else begin
              hpos_nxt = '0;
              res.frame_sequence = seq_r;
              res.kind           = KIND_ERROR;
              if (!hok_r || rate_r != exp_rate_r) begin
                res_valid      = 1'b1;
                res.error_code = ERR_BAD_HEADER;
                phase_nxt      = PH_HALTED;
              end else if (count_fin > MAX_COUNT) begin
                res_valid      = 1'b1;
                res.error_code = ERR_OVERSIZED;
                phase_nxt      = PH_HALTED;
              end else if (have_prev_r && seq_r != next_seq_r) begin
                res_valid      = 1'b1;
                res.error_code = ERR_LOST_FRAME;
                phase_nxt      = PH_HALTED;
              end else begin
                res           = '0;
                next_seq_nxt  = seq_r + 32'd1;
                have_prev_nxt = 1'b1;
                left_nxt      = count_fin[16:0];
                sbp_nxt       = '0;
                i_asm_nxt     = '0;
                q_asm_nxt     = '0;
                if (count_fin[16:0] == 17'd0) begin
                  phase_nxt = PH_HEADER;
                  hok_nxt   = 1'b1;
                end else begin
                  phase_nxt = PH_SAMPLES;
                end
              end
            end
          end

          PH_SAMPLES: begin
            if (sbp_r < SMP_Q_POS) begin
              i_asm_nxt = i_asm_r | ({24'd0, data_byte} << {sbp_r[1:0], 3'd0});
              sbp_nxt   = sbp_r + 3'd1;
            end else if (sbp_r != SMP_LAST_POS) begin
              q_asm_nxt = q_asm_r | ({16'd0, data_byte} << {q_lane, 3'd0});
              sbp_nxt   = sbp_r + 3'd1;
            end else begin
              res_valid          = 1'b1;
              res.kind           = KIND_SAMPLE;
              res.error_code     = ERR_NONE;
              res.i_bits         = i_asm_r;
              res.q_bits         = {data_byte, q_asm_r};
              res.frame_sequence = seq_r;
              res.last_in_frame  = (left_dec == 17'd0);
              left_nxt           = left_dec;
              sbp_nxt            = '0;
              i_asm_nxt          = '0;
              q_asm_nxt          = '0;
              if (left_dec == 17'd0) begin
                phase_nxt = PH_HEADER;
                hpos_nxt  = '0;
                hok_nxt   = 1'b1;
              end
            end
          end

          PH_HALTED: begin
            phase_nxt = PH_HALTED;
          end

          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_rate_r  <= RATE_DEFAULT;
      phase_r     <= PH_HEADER;
      hpos_r      <= '0;
      hok_r       <= 1'b1;
      seq_r       <= '0;
      rate_r      <= '0;
      count_r     <= '0;
      left_r      <= '0;
      sbp_r       <= '0;
      i_asm_r     <= '0;
      q_asm_r     <= '0;
      have_prev_r <= 1'b0;
      next_seq_r  <= '0;
    end else begin
      if (cfg_we) begin
        exp_rate_r <= cfg_data;
      end
      phase_r     <= phase_nxt;
      hpos_r      <= hpos_nxt;
      hok_r       <= hok_nxt;
      seq_r       <= seq_nxt;
      rate_r      <= rate_nxt;
      count_r     <= count_nxt;
      left_r      <= left_nxt;
      sbp_r       <= sbp_nxt;
      i_asm_r     <= i_asm_nxt;
      q_asm_r     <= q_asm_nxt;
      have_prev_r <= have_prev_nxt;
      next_seq_r  <= next_seq_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IQ frame deframer. A queue of stream words
// (frame bytes and restart commands) feeds a clocked driver; a predictor
// tracks the deframer state on every accepted word and a clocked monitor
// compares each result word, field by field, against the oldest prediction.
// The run covers a directed pass, then random frame traffic under several
// expected-rate settings, with random idle bursts on both channels in all but the last.
// ----------------------------------------------------------------------------
module tb_top;
  import iqfd_pkg::*;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } stream_word_t;

  localparam logic        CMD_BYTE              = 1'b0;
  localparam logic        CMD_RESTART           = 1'b1;
  localparam int          NO_CORRUPT            = -1;
  localparam int unsigned RANDOM_WORDS_PER_RATE = 35;
  localparam int unsigned DRAIN_CYCLES          = 4;
  localparam int unsigned RUN_LIMIT_NS          = 2_000_000;
  // Magic, version, type and header length, first stream byte in the top lane.
  localparam logic [63:0] FRAME_LEAD            = 64'h4631_3549_0101_0014;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n        = 1'b0;
  logic        cfg_we       = 1'b0;
  logic [31:0] cfg_data     = '0;
  logic        in_valid     = 1'b0;
  logic        in_command   = 1'b0;
  logic [7:0]  in_data_byte = '0;
  logic        out_stall    = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_kind;
  logic [1:0]  out_error_code;
  logic [31:0] out_i_bits;
  logic [31:0] out_q_bits;
  logic [31:0] out_frame_sequence;
  logic        out_last_in_frame;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  iq_frame_deframer i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_error_code     (out_error_code),
    .out_i_bits         (out_i_bits),
    .out_q_bits         (out_q_bits),
    .out_frame_sequence (out_frame_sequence),
    .out_last_in_frame  (out_last_in_frame)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  stream_word_t pending_words[$];     // words still to be driven
  result_t      predicted_results[$]; // results owed by the deframer, oldest first

  bit          idle_enable = 1'b1;
  bit          word_taken  = 1'b0;
  int unsigned send_gap    = 0;
  int unsigned recv_gap    = 0;
  int unsigned words_queued;
  int unsigned words_accepted;
  int unsigned samples_checked;
  int unsigned errors_checked;
  int unsigned mismatches;

  // Stimulus-side view of the stream, used only to build well-formed frames.
  logic [31:0] gen_rate;
  logic [31:0] gen_seq_next;
  bit          gen_seq_known;

  // Predictor copy of the deframer state and its rate register.
  logic [31:0] pred_rate;
  phase_t      pred_phase;
  logic [4:0]  pred_hdr_pos;
  logic        pred_hdr_good;
  logic [31:0] pred_seq;
  logic [31:0] pred_rate_field;
  logic [31:0] pred_count;
  logic [16:0] pred_left;
  logic [2:0]  pred_smp_pos;
  logic [31:0] pred_i;
  logic [23:0] pred_q;
  logic        pred_seq_known;
  logic [31:0] pred_seq_next;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  task automatic pred_reset();
    pred_rate       = RATE_DEFAULT;
    pred_phase      = PH_HEADER;
    pred_hdr_pos    = '0;
    pred_hdr_good   = 1'b1;
    pred_seq        = '0;
    pred_rate_field = '0;
    pred_count      = '0;
    pred_left       = '0;
    pred_smp_pos    = '0;
    pred_i          = '0;
    pred_q          = '0;
    pred_seq_known  = 1'b0;
    pred_seq_next   = '0;
  endtask

  task automatic halt_with_error(input err_t code);
    result_t r;
    r                = '0;
    r.kind           = KIND_ERROR;
    r.error_code     = code;
    r.frame_sequence = pred_seq;
    predicted_results.push_back(r);
    pred_phase = PH_HALTED;
  endtask

  // Advance the predicted state by one accepted word; queue any result it owes.
  task automatic deframe_word(input stream_word_t w);
    result_t r;
    if (w.command == CMD_RESTART) begin
      // Forget the last sequence and look for a header again.
      pred_seq_known = 1'b0;
      pred_phase     = PH_HEADER;
      pred_hdr_pos   = '0;
      pred_hdr_good  = 1'b1;
    end else if (pred_phase == PH_HEADER) begin
      if (pred_hdr_pos < HDR_SEQ_POS) begin
        if (w.data_byte != FRAME_LEAD[63 - 8 * int'(pred_hdr_pos) -: 8])
          pred_hdr_good = 1'b0;
      end else if (pred_hdr_pos < HDR_RATE_POS) begin
        pred_seq = {pred_seq[23:0], w.data_byte};
      end else if (pred_hdr_pos < HDR_CNT_POS) begin
        pred_rate_field = {pred_rate_field[23:0], w.data_byte};
      end else begin
        pred_count = {pred_count[23:0], w.data_byte};
      end
      if (pred_hdr_pos != HDR_LAST_POS) begin
        pred_hdr_pos = pred_hdr_pos + 5'd1;
      end else begin
        // Header complete: bad header wins over oversized, which wins over lost.
        pred_hdr_pos = '0;
        if (!pred_hdr_good || pred_rate_field != pred_rate) begin
          halt_with_error(ERR_BAD_HEADER);
        end else if (pred_count > MAX_COUNT) begin
          halt_with_error(ERR_OVERSIZED);
        end else if (pred_seq_known && pred_seq != pred_seq_next) begin
          halt_with_error(ERR_LOST_FRAME);
        end else begin
          pred_seq_next  = pred_seq + 32'd1;
          pred_seq_known = 1'b1;
          pred_left      = pred_count[16:0];
          pred_smp_pos   = '0;
          pred_i         = '0;
          pred_q         = '0;
          if (pred_left == 0) begin
            pred_phase    = PH_HEADER;
            pred_hdr_good = 1'b1;
          end else begin
            pred_phase = PH_SAMPLES;
          end
        end
      end
    end else if (pred_phase == PH_SAMPLES) begin
      if (pred_smp_pos < SMP_Q_POS) begin
        pred_i[8 * int'(pred_smp_pos) +: 8] = w.data_byte;
        pred_smp_pos = pred_smp_pos + 3'd1;
      end else if (pred_smp_pos != SMP_LAST_POS) begin
        pred_q[8 * (int'(pred_smp_pos) - int'(SMP_Q_POS)) +: 8] = w.data_byte;
        pred_smp_pos = pred_smp_pos + 3'd1;
      end else begin
        pred_left        = pred_left - 17'd1;
        r                = '0;
        r.kind           = KIND_SAMPLE;
        r.error_code     = ERR_NONE;
        r.i_bits         = pred_i;
        r.q_bits         = {w.data_byte, pred_q};
        r.frame_sequence = pred_seq;
        r.last_in_frame  = (pred_left == 0);
        predicted_results.push_back(r);
        pred_smp_pos = '0;
        pred_i       = '0;
        pred_q       = '0;
        if (pred_left == 0) begin
          pred_phase    = PH_HEADER;
          pred_hdr_pos  = '0;
          pred_hdr_good = 1'b1;
        end
      end
    end
    // Halted: drop the byte, nothing owed.
  endtask

  // Track the rate register and every accepted word at the clock edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      pred_reset();
    end else begin
      if (cfg_we)
        pred_rate = cfg_data;
      if (in_valid && !in_stall) begin
        deframe_word({in_command, in_data_byte});
        word_taken     = 1'b1;
        words_accepted = words_accepted + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: advance when the bus is empty or its word was taken, then either
  // go on with or open an idle burst, or put the next pending word on the bus.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : input_driver
    stream_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      word_taken = 1'b0;
      if (send_gap != 0) begin
        send_gap = send_gap - 1;
        in_valid <= 1'b0;
      end else if (idle_enable && pending_words.size() != 0 && $urandom_range(0, 5) == 0) begin
        // Open an idle burst of random length, starting with this cycle.
        send_gap = $urandom_range(0, 4);
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        in_valid     <= 1'b1;
        in_command   <= w.command;
        in_data_byte <= w.data_byte;
      end else begin
        in_valid <= 1'b0;
      end
    end
    // Otherwise hold the stalled word as it is.
  end

  // Result-side back-pressure in random bursts.
  always @(negedge clk) begin
    if (recv_gap != 0) begin
      recv_gap = recv_gap - 1;
      out_stall <= 1'b1;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      recv_gap = $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches = mismatches + 1;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_results.size() == 0) begin
        $error("unpredicted result word: kind %0d code %0d seq 0x%0h",
               out_kind, out_error_code, out_frame_sequence);
        mismatches = mismatches + 1;
      end else begin
        want = predicted_results.pop_front();
        check_field("out_kind", 32'(want.kind), 32'(out_kind));
        check_field("out_error_code", 32'(want.error_code), 32'(out_error_code));
        check_field("out_i_bits", want.i_bits, out_i_bits);
        check_field("out_q_bits", want.q_bits, out_q_bits);
        check_field("out_frame_sequence", want.frame_sequence, out_frame_sequence);
        check_field("out_last_in_frame", 32'(want.last_in_frame), 32'(out_last_in_frame));
        if (want.kind == KIND_ERROR)
          errors_checked = errors_checked + 1;
        else
          samples_checked = samples_checked + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  task automatic queue_word(input logic cmd, input logic [7:0] b);
    stream_word_t w;
    w.command   = cmd;
    w.data_byte = b;
    pending_words.push_back(w);
    words_queued = words_queued + 1;
  endtask

  task automatic queue_restart();
    queue_word(CMD_RESTART, 8'($urandom));
    gen_seq_known = 1'b0;
  endtask

  // Queue the first upto header bytes; flip byte bad_pos of the fixed lead.
  task automatic queue_header(input logic [31:0] seq, input logic [31:0] rate,
                              input logic [31:0] count, input int bad_pos,
                              input int upto);
    logic [159:0] hdr;
    logic [7:0]   b;
    hdr = {FRAME_LEAD, seq, rate, count};
    for (int k = 0; k < upto; k++) begin
      b = hdr[159 - 8 * k -: 8];
      if (k == bad_pos)
        b ^= 8'($urandom_range(1, 255));
      queue_word(CMD_BYTE, b);
    end
  endtask

  task automatic queue_samples(input int n);
    repeat (8 * n) queue_word(CMD_BYTE, 8'($urandom));
  endtask

  // Whole frame with the next sequence in line, or any sequence after a restart.
  task automatic queue_good_frame(input int count);
    logic [31:0] seq;
    seq = gen_seq_known ? gen_seq_next : $urandom;
    queue_header(seq, gen_rate, count, NO_CORRUPT, HEADER_BYTES);
    queue_samples(count);
    gen_seq_next  = seq + 32'd1;
    gen_seq_known = 1'b1;
  endtask

  // After an error: a few bytes the halted block must drop, then a restart.
  task automatic queue_halt_tail();
    repeat ($urandom_range(0, 3)) queue_word(CMD_BYTE, 8'($urandom));
    queue_restart();
  endtask

  task automatic queue_random_traffic(input int unsigned n_words);
    int unsigned stop_at;
    int unsigned pick;
    logic [31:0] count;
    stop_at = words_queued + n_words;
    while (words_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        queue_good_frame(($urandom_range(0, 9) == 0) ? $urandom_range(5, 12)
                                                     : $urandom_range(0, 4));
      end else if (pick < 68) begin
        // Broken magic, version, type or length byte.
        queue_header($urandom, gen_rate, $urandom, $urandom_range(0, 7), HEADER_BYTES);
        queue_halt_tail();
      end else if (pick < 74) begin
        queue_header($urandom, gen_rate ^ (32'd1 << $urandom_range(0, 31)), $urandom,
                     NO_CORRUPT, HEADER_BYTES);
        queue_halt_tail();
      end else if (pick < 80) begin
        count = ($urandom_range(0, 3) == 0) ? $urandom_range(MAX_SAMPLES + 1, MAX_SAMPLES + 300)
                                            : $urandom_range(MAX_SAMPLES + 1, 32'hFFFF_FFFF);
        queue_header($urandom, gen_rate, count, NO_CORRUPT, HEADER_BYTES);
        queue_halt_tail();
      end else if (pick < 86) begin
        if (gen_seq_known) begin
          queue_header(gen_seq_next + $urandom_range(1, 32'hFFFF_FFFE), gen_rate,
                       $urandom_range(0, 4), NO_CORRUPT, HEADER_BYTES);
          queue_halt_tail();
        end else begin
          queue_good_frame(1);
        end
      end else if (pick < 93) begin
        // Cut a frame short, in the header or among the samples.
        if ($urandom_range(0, 1) == 0) begin
          queue_header($urandom, gen_rate, $urandom, NO_CORRUPT,
                       $urandom_range(1, HEADER_BYTES - 1));
        end else begin
          queue_header(gen_seq_known ? gen_seq_next : $urandom, gen_rate, 4,
                       NO_CORRUPT, HEADER_BYTES);
          repeat ($urandom_range(0, 31)) queue_word(CMD_BYTE, 8'($urandom));
        end
        queue_restart();
      end else begin
        // Raw noise, then recover.
        repeat ($urandom_range(1, 30)) queue_word(CMD_BYTE, 8'($urandom));
        queue_restart();
      end
    end
  endtask

  // Wait until the driver is empty and every owed result has been taken,
  // then leave room for words that owe nothing but may still be in flight.
  // Check at the rising edge, where the driven valid is settled.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || predicted_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Called at a falling edge with the block idle.
  task automatic write_rate(input logic [31:0] rate);
    cfg_we   <= 1'b1;
    cfg_data <= rate;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic run_rate_phase(input logic [31:0] rate, input bit idle);
    idle_enable = idle;
    write_rate(rate);
    gen_rate = rate;
    queue_random_traffic(RANDOM_WORDS_PER_RATE);
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    words_queued    = 0;
    words_accepted  = 0;
    samples_checked = 0;
    errors_checked  = 0;
    mismatches      = 0;
    gen_rate        = RATE_DEFAULT;
    gen_seq_known   = 1'b0;
    gen_seq_next    = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed pass at the reset rate.
    queue_restart();                     // restart with nothing in progress
    // Sequence wrap: all-ones frame with extreme samples, then frame zero, empty.
    queue_header(32'hFFFF_FFFF, gen_rate, 2, NO_CORRUPT, HEADER_BYTES);
    repeat (8) queue_word(CMD_BYTE, 8'h00);
    repeat (8) queue_word(CMD_BYTE, 8'hFF);
    gen_seq_known = 1'b1;
    gen_seq_next  = 32'd0;
    queue_good_frame(0);
    queue_good_frame(1);
    // Lost frame; the bytes after it must be dropped while halted.
    queue_header(gen_seq_next + 32'd3, gen_rate, 1, NO_CORRUPT, HEADER_BYTES);
    queue_word(CMD_BYTE, 8'h00);
    queue_word(CMD_BYTE, 8'hFF);
    queue_restart();
    // Bad magic, then a rate mismatch.
    queue_header($urandom, gen_rate, 1, 0, HEADER_BYTES);
    queue_restart();
    queue_header($urandom, gen_rate + 32'd1, 1, NO_CORRUPT, HEADER_BYTES);
    queue_restart();
    // One past the sample limit.
    queue_header($urandom, gen_rate, MAX_SAMPLES + 1, NO_CORRUPT, HEADER_BYTES);
    queue_restart();
    // Priority: bad version over oversized over lost; then oversized over lost.
    queue_good_frame(1);
    queue_header(gen_seq_next + 32'd7, gen_rate, 32'hFFFF_FFFF, 4, HEADER_BYTES);
    queue_restart();
    queue_good_frame(0);
    queue_header(gen_seq_next + 32'd7, gen_rate, 32'd70000, NO_CORRUPT, HEADER_BYTES);
    queue_restart();
    // Largest legal count is accepted; abandon it part way through a sample.
    queue_header($urandom, gen_rate, MAX_SAMPLES, NO_CORRUPT, HEADER_BYTES);
    queue_samples(2);
    repeat (3) queue_word(CMD_BYTE, 8'($urandom));
    queue_restart();
    // Restart in the middle of a header, then a clean frame.
    queue_header($urandom, gen_rate, 1, NO_CORRUPT, 10);
    queue_restart();
    queue_good_frame(3);
    wait_drained();

    // Random traffic across rate settings; the last one runs without idling.
    run_rate_phase(32'd0, 1'b1);
    run_rate_phase(32'hFFFF_FFFF, 1'b1);
    run_rate_phase($urandom, 1'b1);
    run_rate_phase(RATE_DEFAULT, 1'b0);

    repeat (8) @(negedge clk);
    if (predicted_results.size() != 0) begin
      $error("%0d predicted results never arrived", predicted_results.size());
      mismatches = mismatches + 1;
    end

    $display("summary: %0d stream words accepted, %0d sample and %0d error results checked",
             words_accepted, samples_checked, errors_checked);
    $display("summary: five rate settings incl. 0 and all-ones, %0d mismatches", mismatches);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Hard stop in case the stream or the results stall for good.
  initial begin
    #(RUN_LIMIT_NS);
    $error("run limit reached with %0d words pending and %0d results owed",
           pending_words.size(), predicted_results.size());
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/iqfd_pkg.sv
rtl/iqfd_core.sv
rtl/iq_frame_deframer.sv
tb/tb_top.sv
